/* rtl/swa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and constants of the sliding window average filter.
// ----------------------------------------------------------------------------
package swa_pkg;

	localparam int unsigned CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd5;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

/* rtl/swa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swa_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/swa_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swa_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swa_divider
	import swa_pkg::*;
#(
	parameter int unsigned DIVIDEND_W = 22,
	parameter int unsigned DIVISOR_W  = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire div_ctrl_t             ctrl,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output div_stat_t                  stat,
	output logic      [DIVIDEND_W-1:0] quotient
);

	localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [STEP_W-1:0]     cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_diff;
	logic                  fits;

	always_comb begin
		rem_sh   = {rem_q, quo_q[DIVIDEND_W-1]};
		rem_diff = rem_sh - {1'b0, dvs_q};
		fits     = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops cleanly
			rem_q <= fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

/* rtl/sliding_window_average_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_average_core
// Moving average over the most recent samples, ring held in a RAM.
// ----------------------------------------------------------------------------
// Sequence per sample: ring read and sum update, then a bit-serial division of
//   SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) bits (22 at defaults), then result.
// A new sample is accepted only once the previous average is registered for
//   output; an unread result stalls input only once the next is ready.
// Reset: window length 5 (capped at MAX_WINDOW), sum, count and slot cleared;
//   ring RAM contents are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
module sliding_window_average_core
	import swa_pkg::*;
#(
	parameter int unsigned MAX_WINDOW  = 64,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration: window_length
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [CFG_W-1:0]                     cfg_data,
	// input samples
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // [SAMPLE_BITS-1:0] sample
	// output averages
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata   // [SAMPLE_BITS-1:0] average
);

	localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int unsigned ADDR_W = $clog2(MAX_WINDOW);
	localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int unsigned SUM_W  = SAMPLE_BITS + ADDR_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_UPDATE = 3'd1;
	localparam logic [2:0] ST_START  = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	function automatic logic [CNT_W-1:0] eff_len(input logic [CFG_W-1:0] v);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(v);
		if (ext == '0) begin
			return CNT_W'(1);
		end else if (ext > CMP_W'(MAX_WINDOW)) begin
			return CNT_W'(MAX_WINDOW);
		end else begin
			return CNT_W'(ext);
		end
	endfunction

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       len_q;
	logic [CNT_W-1:0]       held_q;
	logic [ADDR_W-1:0]      slot_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   neg_q;
	logic [SAMPLE_BITS-1:0] out_q;
	logic                   out_valid_q;

	logic                   s_accept;
	logic                   cfg_accept;
	logic                   out_free;
	logic                   result_load;
	logic                   full;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       old_ext;
	logic [SUM_W-1:0]       new_ext;
	logic [SUM_W-1:0]       mag;
	logic [SAMPLE_BITS-1:0] quo_lo;
	logic [SAMPLE_BITS-1:0] avg;
	logic [CNT_W-1:0]       slot_inc;
	div_ctrl_t              div_ctrl;
	div_stat_t              div_stat;
	logic [SUM_W-1:0]       div_quo;

	// config only between samples; a pending config transaction goes first
	assign cfg_ready  = (state_q == ST_IDLE);
	assign cfg_accept = cfg_valid & cfg_ready;
	assign s_tready   = (state_q == ST_IDLE) && !cfg_valid;
	assign s_accept   = s_tvalid & s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = DATA_W'(out_q);

	swa_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == ST_UPDATE),
		.wr_addr (slot_q),
		.wr_data (sample_q),
		.rd_en   (s_accept),
		.rd_addr (slot_q),
		.rd_data (old_sample)
	);

	always_comb begin
		full     = (held_q == len_q);
		old_ext  = {{ADDR_W{old_sample[SAMPLE_BITS-1]}}, old_sample};
		new_ext  = {{ADDR_W{sample_q[SAMPLE_BITS-1]}}, sample_q};
		slot_inc = CNT_W'(slot_q) + 1'b1;
		mag      = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
		quo_lo   = div_quo[SAMPLE_BITS-1:0];
		avg      = neg_q ? (~quo_lo + 1'b1) : quo_lo;
		div_ctrl.start = (state_q == ST_START);
		result_load = (((state_q == ST_WAIT) && div_stat.done) || (state_q == ST_DONE))
			&& out_free;
	end

	swa_divider #(
		.DIVIDEND_W(SUM_W),
		.DIVISOR_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (mag),
		.divisor  (held_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= eff_len(WINDOW_RESET);
			held_q      <= '0;
			slot_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_accept) begin
				len_q  <= eff_len(cfg_data);
				held_q <= '0;
				slot_q <= '0;
				sum_q  <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// ring read of the oldest sample landed this cycle
					sum_q  <= sum_q - (full ? old_ext : '0) + new_ext;
					held_q <= full ? held_q : held_q + 1'b1;
					slot_q <= (slot_inc == len_q) ? '0 : slot_inc[ADDR_W-1:0];
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_stat.done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_START) begin
			neg_q <= sum_q[SUM_W-1];
		end
		if (result_load) begin
			out_q <= avg;
		end
	end

	// held count never passes the window length
	assert property (@(posedge clk) disable iff (!arst_n) held_q <= len_q)
		else $error("held count above window length");

	// write slot stays inside the window
	assert property (@(posedge clk) disable iff (!arst_n) CNT_W'(slot_q) < len_q)
		else $error("write slot outside window");

	// divider completes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_WAIT))
		else $error("divider done outside wait state");

	// a new result appears only from the wait or hold states
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_WAIT || $past(state_q) == ST_DONE))
		else $error("result raised outside completion");

	// no new sample is taken while the divider runs
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !s_tready)
		else $error("input ready during division");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for sliding_window_average_core. A scoreboard keeps its own
// window, sum and fill count, predicts one average per accepted sample, and
// compares it with each output transaction. Directed cases cover the reset
// window, the full-scale samples, the length limits and truncation toward
// zero. Random phases then rewrite the window length and stream samples.
// Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb
	import swa_pkg::*;
();

	localparam int unsigned MAX_WIN   = 64;
	localparam int unsigned DATA_W    = 16;
	localparam int unsigned LIMIT     = 400000;
	localparam int unsigned RAND_ITEMS = 430;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [DATA_W-1:0]        s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [DATA_W-1:0]        m_tdata;

	// scoreboard copy of the filter state
	logic [CFG_W-1:0]         win_reg;
	logic signed [DATA_W-1:0] ring_mem [MAX_WIN];
	int unsigned              next_slot;
	int unsigned              fill_count;
	longint                   window_sum;

	logic signed [DATA_W-1:0] average_q [$];

	int unsigned cycle_cnt;
	int unsigned n_samples;
	int unsigned n_averages;
	int unsigned n_cfg;
	int unsigned n_errors;
	int unsigned stall_left;
	bit          quiet;

	sliding_window_average_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("timeout after %0d cycles, %0d averages pending", cycle_cnt,
				average_q.size());
			$display("sliding_window_average_core regression: fail");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	function automatic int unsigned window_in_use();
		if (win_reg == 0)
			return 1;
		if (win_reg > MAX_WIN)
			return MAX_WIN;
		return win_reg;
	endfunction

	function automatic logic signed [DATA_W-1:0] predict_average(
		logic signed [DATA_W-1:0] smp);
		int unsigned len;
		int unsigned slot;
		longint      avg;
		len  = window_in_use();
		slot = next_slot % len;
		if (fill_count >= len) begin
			window_sum -= ring_mem[slot];
			fill_count = len;
		end else begin
			fill_count++;
		end
		ring_mem[slot] = smp;
		window_sum += smp;
		next_slot = (slot + 1) % len;
		avg = window_sum / longint'(fill_count);
		return avg[DATA_W-1:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_averages++;
			if (average_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected average %0d", $signed(m_tdata));
			end else begin
				logic signed [DATA_W-1:0] exp_avg;
				exp_avg = average_q[0];
				average_q.delete(0);
				if (m_tdata !== exp_avg) begin
					n_errors++;
					if (n_errors <= 10)
						$display("average mismatch: expected %0d, got %0d (0x%h)",
							exp_avg, $signed(m_tdata), m_tdata);
				end
			end
		end
	end

	task automatic send_sample(input logic signed [DATA_W-1:0] smp);
		int unsigned gap;
		gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap != 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
		average_q = {average_q, predict_average(smp)};
		n_samples++;
	endtask

	// lower valid and wait until every average has come back
	task automatic drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (average_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] len);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		win_reg    = len;
		next_slot  = 0;
		fill_count = 0;
		window_sum = 0;
		n_cfg++;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [DATA_W-1:0] rand_sample(int unsigned style);
		case (style)
			0: return DATA_W'($urandom());
			1: return ($urandom_range(0, 9) == 0) ? 16'sh8000 : 16'sh7fff;
			2: return ($urandom_range(0, 9) == 0) ? 16'sh7fff : 16'sh8000;
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
					default: return DATA_W'($urandom());
				endcase
			end
		endcase
	endfunction

	// window of 5 out of reset: fill, wrap, both full-scale values, signs
	task automatic test_reset_window();
		logic signed [DATA_W-1:0] mix [5] = '{16'sd3, -16'sd4, 16'sd0, -16'sd1, -16'sd2};
		repeat (6) send_sample(16'sh7fff);
		repeat (6) send_sample(16'sh8000);
		foreach (mix[i]) send_sample(mix[i]);
	endtask

	// zero acts as one, a window of one, rounding toward zero
	task automatic test_length_limits();
		write_window(7'd0);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(-16'sd1);
		write_window(7'd1);
		send_sample(16'sd7);
		send_sample(-16'sd9);
		write_window(7'd2);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_sample(16'sd3);
	endtask

	task automatic test_random_phases();
		int unsigned sent;
		int unsigned phase;
		int unsigned count;
		int unsigned style;
		logic [CFG_W-1:0] len;
		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			// first phases pin the largest windows with full-scale runs
			case (phase)
				0: begin len = 7'd127; style = 1; count = 70; end
				1: begin len = 7'd64;  style = 2; count = 70; end
				2: begin len = 7'd65;  style = 3; count = 40; end
				default: begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: len = CFG_W'($urandom_range(1, 8));
						4, 5, 6:    len = CFG_W'($urandom_range(9, 64));
						7:          len = CFG_W'($urandom_range(0, 1));
						default:    len = CFG_W'($urandom_range(65, 127));
					endcase
					style = $urandom_range(0, 3);
					count = $urandom_range(20, 50);
				end
			endcase
			quiet = (phase % 4 == 3);
			write_window(len);
			repeat (count) send_sample(rand_sample(style));
			sent += count;
			phase++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		win_reg    = WINDOW_RESET;
		next_slot  = 0;
		fill_count = 0;
		window_sum = 0;
		foreach (ring_mem[i]) ring_mem[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reset_window();
		test_length_limits();
		test_random_phases();

		drain();
		repeat (60) @(posedge clk);
		if (average_q.size() != 0) begin
			n_errors++;
			$display("%0d averages never arrived", average_q.size());
		end
		$display("%0d samples sent, %0d averages checked, %0d window length writes",
			n_samples, n_averages, n_cfg);
		$display("%0d errors in %0d cycles", n_errors, cycle_cnt);
		if (n_errors == 0) begin
			$display("sliding_window_average_core regression: pass");
		end else begin
			$display("sliding_window_average_core regression: fail");
		end
		$finish;
	end

endmodule
